[rtl/rgbv210_pkg.sv]
`timescale 1ns / 1ps

package rgbv210_pkg;

	// Queue between front and back, in groups
	localparam int QUEUE_DEPTH = 4;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_WIDE_GAMUT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_KEY  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 2'd2;

	localparam int COL_W = 13;
	localparam logic [COL_W-1:0] MAX_ROW_WIDTH   = 13'd8191;
	localparam logic [COL_W-1:0] ROW_WIDTH_RESET = 13'd1920;

	// Samples and words
	localparam int CHAN_W          = 8;
	localparam int SAMPLE_W        = 10;
	localparam int WORD_W          = 3 * SAMPLE_W;
	localparam int WORDS_PER_GROUP = 4;
	localparam int PIX_PER_GROUP   = 6;

	localparam logic [SAMPLE_W-1:0] BLACK_Y = 10'd64;
	localparam logic [SAMPLE_W-1:0] BLACK_C = 10'd512;

	// Black group words: Cb Y Cr on even words, Y C Y on odd words
	localparam logic [WORD_W-1:0] BLACK_WORD_EVEN = {BLACK_C, BLACK_Y, BLACK_C};
	localparam logic [WORD_W-1:0] BLACK_WORD_ODD  = {BLACK_Y, BLACK_C, BLACK_Y};

	// One finished group: four words, black groups to follow, row end flag
	typedef struct packed {
		logic [WORDS_PER_GROUP-1:0][WORD_W-1:0] words;
		logic [2:0]                             pad_groups;
		logic                                   row_end;
	} grp_entry_t;

	// Group word with its valid, used for queue push and queue head
	typedef struct packed {
		logic       valid;
		grp_entry_t entry;
	} grp_slot_t;

endpackage

[rtl/rgbv210_ifs.sv]
`timescale 1ns / 1ps

// Pixel channel
interface rgbv210_pix_if;
	logic                           valid;
	logic                           ready;
	logic [rgbv210_pkg::CHAN_W-1:0] red;
	logic [rgbv210_pkg::CHAN_W-1:0] green;
	logic [rgbv210_pkg::CHAN_W-1:0] blue;
	logic [rgbv210_pkg::CHAN_W-1:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// Packed video word channel
interface rgbv210_word_if;
	logic                           valid;
	logic                           ready;
	logic [rgbv210_pkg::WORD_W-1:0] video_word;
	logic                           row_done;

	modport source (output valid, video_word, row_done, input ready);
	modport sink   (input valid, video_word, row_done, output ready);
endinterface

// Configuration write channel
interface rgbv210_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [rgbv210_pkg::CFG_INDEX_W-1:0] index;
	logic [rgbv210_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rgbv210_front.sv]
`timescale 1ns / 1ps

module rgbv210_front #(
	parameter int DEPTH = rgbv210_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rgbv210_cfg_if.sink            cfg,
	rgbv210_pix_if.sink            pix,
	input  logic                   pop,
	output rgbv210_pkg::grp_slot_t push
);

	localparam int SW    = rgbv210_pkg::SAMPLE_W;
	localparam int CW    = rgbv210_pkg::COL_W;
	localparam int RES_W = $clog2(DEPTH + 1);
	localparam logic [RES_W-1:0] RES_FULL = RES_W'(DEPTH);

	// Coefficients: Y r g b, Cb r g b, Cr r g b
	localparam logic signed [21:0] COEF_709 [9] = '{
		22'sd222951,  22'sd750098,  22'sd75663,
		-22'sd100459, -22'sd337802, 22'sd438223,
		22'sd438223,  -22'sd398337, -22'sd39908
	};
	localparam logic signed [21:0] COEF_2020 [9] = '{
		22'sd275375,  22'sd710743,  22'sd62594,
		-22'sd146420, -22'sd377856, 22'sd524288,
		22'sd524288,  -22'sd482393, -22'sd41857
	};

	typedef struct packed {
		logic [2:0] slot;
		logic       emit;
		logic       row_end;
		logic [2:0] pad_groups;
	} pix_tag_t;

	// round(v * 1023 / 255) for an 8-bit value
	function automatic logic [SW-1:0] scale10(input logic [7:0] v);
		logic [SW-1:0] r;
		r = {v, 2'b00};
		r = r + SW'(v >= 8'd43) + SW'(v >= 8'd128) + SW'(v >= 8'd213);
		return r;
	endfunction

	// Floor shift by 20, add offset, clamp
	function automatic logic [SW-1:0] clamp_sample(input logic signed [31:0] sum,
		input logic [SW-1:0] ofs, input logic [SW-1:0] lo, input logic [SW-1:0] hi);
		logic signed [12:0] v;
		v = $signed({sum[31], sum[31:20]}) + $signed({3'b000, ofs});
		if (v < $signed({3'b000, lo})) begin
			return lo;
		end else if (v > $signed({3'b000, hi})) begin
			return hi;
		end
		return v[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] avg2(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b} + (SW+1)'(1);
		return s[SW:1];
	endfunction

	// Configuration registers
	logic          wide_gamut_q;
	logic          alpha_key_q;
	logic [CW-1:0] row_width_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_gamut_q <= 1'b0;
			alpha_key_q  <= 1'b0;
			row_width_q  <= rgbv210_pkg::ROW_WIDTH_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				rgbv210_pkg::REG_WIDE_GAMUT: wide_gamut_q <= cfg.data[0];
				rgbv210_pkg::REG_ALPHA_KEY:  alpha_key_q  <= cfg.data[0];
				rgbv210_pkg::REG_ROW_WIDTH:  row_width_q  <= cfg.data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Row position state
	logic [CW-1:0] column_count_q;
	logic [2:0]    slot_index_q;
	logic [2:0]    group_in_block_q;
	logic [RES_W-1:0] reserved_q;

	logic          accept;
	logic [CW-1:0] width;
	logic [2:0]    slot;
	logic          last;
	logic [2:0]    gib_next;
	pix_tag_t      tag_now;

	assign pix.ready = (reserved_q != RES_FULL);
	assign accept    = pix.valid && pix.ready;

	always_comb begin
		width    = (row_width_q > rgbv210_pkg::MAX_ROW_WIDTH) ?
			rgbv210_pkg::MAX_ROW_WIDTH : row_width_q;
		slot     = (slot_index_q > 3'd5) ? 3'd5 : slot_index_q;
		last     = ({1'b0, column_count_q} + (CW+1)'(1)) >= {1'b0, width};
		gib_next = group_in_block_q + 3'd1;
		tag_now.slot       = slot;
		tag_now.emit       = (slot == 3'd5) || last;
		tag_now.row_end    = last;
		tag_now.pad_groups = last ? (3'd0 - gib_next) : 3'd0;
	end

	// Advance row position on each accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q   <= '0;
			slot_index_q     <= '0;
			group_in_block_q <= '0;
		end else if (accept) begin
			if (!tag_now.emit) begin
				slot_index_q   <= slot + 3'd1;
				column_count_q <= column_count_q + CW'(1);
			end else begin
				slot_index_q <= '0;
				if (last) begin
					column_count_q   <= '0;
					group_in_block_q <= '0;
				end else begin
					column_count_q   <= column_count_q + CW'(1);
					group_in_block_q <= gib_next;
				end
			end
		end
	end

	// Reserve a queue place for every group that is on its way
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			case ({accept && tag_now.emit, pop})
				2'b10:   reserved_q <= reserved_q + RES_W'(1);
				2'b01:   reserved_q <= reserved_q - RES_W'(1);
				default: ;
			endcase
		end
	end

	// Stage 1: scale channels to 10 bits
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	pix_tag_t            tag_s1, tag_s2, tag_s3, tag_s4;
	logic [SW-1:0]       rgb_s1 [3];
	logic                bt_s1;
	logic signed [31:0]  prod_s2 [9];
	logic signed [31:0]  sum_s3 [3];
	logic [SW-1:0]       y_s4, cb_s4, cr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= tag_now;
		bt_s1  <= wide_gamut_q;
		if (alpha_key_q) begin
			rgb_s1[0] <= scale10(pix.alpha);
			rgb_s1[1] <= scale10(pix.alpha);
			rgb_s1[2] <= scale10(pix.alpha);
		end else begin
			rgb_s1[0] <= scale10(pix.red);
			rgb_s1[1] <= scale10(pix.green);
			rgb_s1[2] <= scale10(pix.blue);
		end
	end

	// Stage 2: nine coefficient products
	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		for (int k = 0; k < 9; k++) begin
			prod_s2[k] <= (bt_s1 ? COEF_2020[k] : COEF_709[k]) *
				$signed({1'b0, rgb_s1[k % 3]});
		end
	end

	// Stage 3: sum per component
	always_ff @(posedge clk) begin
		tag_s3 <= tag_s2;
		for (int c = 0; c < 3; c++) begin
			sum_s3[c] <= prod_s2[3*c] + prod_s2[3*c+1] + prod_s2[3*c+2];
		end
	end

	// Stage 4: shift, offset and clamp
	always_ff @(posedge clk) begin
		tag_s4 <= tag_s3;
		y_s4   <= clamp_sample(sum_s3[0], rgbv210_pkg::BLACK_Y, 10'd64, 10'd940);
		cb_s4  <= clamp_sample(sum_s3[1], rgbv210_pkg::BLACK_C, 10'd64, 10'd960);
		cr_s4  <= clamp_sample(sum_s3[2], rgbv210_pkg::BLACK_C, 10'd64, 10'd960);
	end

	// Hold the first five pixels of a group
	logic [SW-1:0] luma_hold_q      [5];
	logic [SW-1:0] blue_diff_hold_q [5];
	logic [SW-1:0] red_diff_hold_q  [5];

	always_ff @(posedge clk) begin
		if (valid_s4 && !tag_s4.emit) begin
			luma_hold_q[tag_s4.slot]      <= y_s4;
			blue_diff_hold_q[tag_s4.slot] <= cb_s4;
			red_diff_hold_q[tag_s4.slot]  <= cr_s4;
		end
	end

	// Assemble the group: held pixels, current pixel, black fill
	logic [SW-1:0] gy  [6];
	logic [SW-1:0] gcb [6];
	logic [SW-1:0] gcr [6];
	logic [SW-1:0] b0, b1, b2, r0, r1, r2;

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			if (3'(i) < tag_s4.slot) begin
				gy[i]  = luma_hold_q[i];
				gcb[i] = blue_diff_hold_q[i];
				gcr[i] = red_diff_hold_q[i];
			end else if (3'(i) == tag_s4.slot) begin
				gy[i]  = y_s4;
				gcb[i] = cb_s4;
				gcr[i] = cr_s4;
			end else begin
				gy[i]  = rgbv210_pkg::BLACK_Y;
				gcb[i] = rgbv210_pkg::BLACK_C;
				gcr[i] = rgbv210_pkg::BLACK_C;
			end
		end
		if (tag_s4.slot == 3'd5) begin
			gy[5]  = y_s4;
			gcb[5] = cb_s4;
			gcr[5] = cr_s4;
		end else begin
			gy[5]  = rgbv210_pkg::BLACK_Y;
			gcb[5] = rgbv210_pkg::BLACK_C;
			gcr[5] = rgbv210_pkg::BLACK_C;
		end
		b0 = avg2(gcb[0], gcb[1]);
		b1 = avg2(gcb[2], gcb[3]);
		b2 = avg2(gcb[4], gcb[5]);
		r0 = avg2(gcr[0], gcr[1]);
		r1 = avg2(gcr[2], gcr[3]);
		r2 = avg2(gcr[4], gcr[5]);

		push.valid            = valid_s4 && tag_s4.emit;
		push.entry.words[0]   = {r0, gy[0], b0};
		push.entry.words[1]   = {gy[2], b1, gy[1]};
		push.entry.words[2]   = {b2, gy[3], r1};
		push.entry.words[3]   = {gy[5], r2, gy[4]};
		push.entry.pad_groups = tag_s4.pad_groups;
		push.entry.row_end    = tag_s4.row_end;
	end

endmodule

[rtl/rgbv210_queue.sv]
`timescale 1ns / 1ps

module rgbv210_queue #(
	parameter int DEPTH = rgbv210_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rgbv210_pkg::grp_slot_t push,
	input  logic                   pop,
	output rgbv210_pkg::grp_slot_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	rgbv210_pkg::grp_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Store pushed groups; the front never pushes into a full queue
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

endmodule

[rtl/rgbv210_back.sv]
`timescale 1ns / 1ps

module rgbv210_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rgbv210_pkg::grp_slot_t head,
	output logic                   pop,
	rgbv210_word_if.source         word
);

	localparam int WW = rgbv210_pkg::WORD_W;

	logic [1:0]    idx_q;
	logic          pad_phase_q;
	logic [2:0]    pads_left_q;
	logic          out_valid_q;
	logic [WW-1:0] out_word_q;
	logic          out_done_q;

	logic          adv;
	logic          take;
	logic          last_of_group;
	logic          last_of_entry;
	logic [WW-1:0] next_word;

	assign adv  = !out_valid_q || word.ready;
	assign take = adv && head.valid;

	always_comb begin
		last_of_group = (idx_q == 2'd3);
		if (pad_phase_q) begin
			last_of_entry = last_of_group && (pads_left_q == 3'd1);
			next_word     = idx_q[0] ? rgbv210_pkg::BLACK_WORD_ODD :
				rgbv210_pkg::BLACK_WORD_EVEN;
		end else begin
			last_of_entry = last_of_group && (head.entry.pad_groups == 3'd0);
			next_word     = head.entry.words[idx_q];
		end
	end

	assign pop = take && last_of_entry;

	// Step through group words, then black groups
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pad_phase_q <= 1'b0;
			pads_left_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
			if (last_of_entry) begin
				pad_phase_q <= 1'b0;
			end else if (last_of_group) begin
				if (pad_phase_q) begin
					pads_left_q <= pads_left_q - 3'd1;
				end else begin
					pad_phase_q <= 1'b1;
					pads_left_q <= head.entry.pad_groups;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_word_q <= next_word;
			out_done_q <= last_of_entry && head.entry.row_end;
		end
	end

	assign word.valid      = out_valid_q;
	assign word.video_word = out_word_q;
	assign word.row_done   = out_done_q;

endmodule

[rtl/rgbv210_to_v210_packer_top.sv]
`timescale 1ns / 1ps

// Channel  Dir  Fields
// cfg      in   index (2b), data (13b): 0 wide gamut, 1 alpha key, 2 row width
// pix      in   red, green, blue, alpha (8b each)
// word     out  video_word (30b), row_done (1b)
//
// One pixel per cycle while pix.ready is high; every sixth pixel (or the last of a
// row) makes a group of four words, which leave through the output register at one
// word per cycle while word.ready is high. A group is queued once its last pixel has
// passed scale, multiply, sum and clamp and been assembled. At row end up to seven
// black groups follow (up to 28 words); pix.ready falls while QUEUE_DEPTH groups are
// in flight or queued. Reset clears control only.
module rgb_to_v210_packer_top #(
	parameter int QUEUE_DEPTH = rgbv210_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	rgbv210_cfg_if.sink    cfg,
	rgbv210_pix_if.sink    pix,
	rgbv210_word_if.source word
);

	rgbv210_pkg::grp_slot_t push;
	rgbv210_pkg::grp_slot_t head;
	logic                   pop;

	rgbv210_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.pop    (pop),
		.push   (push)
	);

	rgbv210_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head)
	);

	rgbv210_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.word   (word)
	);

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY_WAIT = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	// Index with no register behind it; writes to it are ignored
	localparam logic [rgbv210_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [rgbv210_pkg::CHAN_W-1:0] red;
		logic [rgbv210_pkg::CHAN_W-1:0] green;
		logic [rgbv210_pkg::CHAN_W-1:0] blue;
		logic [rgbv210_pkg::CHAN_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [rgbv210_pkg::WORD_W-1:0] video_word;
		logic                           row_done;
	} v210_word_t;

	logic clk;
	logic arst_n;

	rgbv210_cfg_if  cfg_bus ();
	rgbv210_pix_if  pix_bus ();
	rgbv210_word_if word_bus ();

	rgb_to_v210_packer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.pix    (pix_bus),
		.word   (word_bus)
	);

	// Packer state as the block should hold it
	logic                             cfg_bt2020;
	logic                             cfg_key;
	logic [rgbv210_pkg::COL_W-1:0]    cfg_width;
	logic [rgbv210_pkg::COL_W-1:0]    col_pos;
	logic [2:0]                       slot_pos;
	logic [2:0]                       group_pos;
	logic [rgbv210_pkg::SAMPLE_W-1:0] luma_hold [5];
	logic [rgbv210_pkg::SAMPLE_W-1:0] cb_hold [5];
	logic [rgbv210_pkg::SAMPLE_W-1:0] cr_hold [5];

	v210_word_t pending_words [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request  = 0;
	int failures      = 0;
	int pixels_sent   = 0;
	int words_checked = 0;
	int rows_seen     = 0;
	int cycle_count   = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Scale 8-bit channel to 10 bits, rounding to nearest
	function automatic int scale_to_10(logic [rgbv210_pkg::CHAN_W-1:0] v);
		return (int'(v) * 2046 + 255) / 510;
	endfunction

	function automatic logic [rgbv210_pkg::SAMPLE_W-1:0] clamp_sample(longint v,
			longint lo, longint hi);
		longint c;
		c = v;
		if (c < lo) c = lo;
		if (c > hi) c = hi;
		return c[rgbv210_pkg::SAMPLE_W-1:0];
	endfunction

	// Matrix with floor shift by 20, then clamp to legal range
	function automatic void rgb_to_ycc(input longint r, input longint g, input longint b,
			output logic [rgbv210_pkg::SAMPLE_W-1:0] y,
			output logic [rgbv210_pkg::SAMPLE_W-1:0] cb,
			output logic [rgbv210_pkg::SAMPLE_W-1:0] cr);
		longint ys, bs, rs;
		if (cfg_bt2020) begin
			ys = 275375 * r + 710743 * g + 62594 * b;
			bs = -146420 * r - 377856 * g + 524288 * b;
			rs = 524288 * r - 482393 * g - 41857 * b;
		end else begin
			ys = 222951 * r + 750098 * g + 75663 * b;
			bs = -100459 * r - 337802 * g + 438223 * b;
			rs = 438223 * r - 398337 * g - 39908 * b;
		end
		y  = clamp_sample(64 + (ys >>> 20), 64, 940);
		cb = clamp_sample(512 + (bs >>> 20), 64, 960);
		cr = clamp_sample(512 + (rs >>> 20), 64, 960);
	endfunction

	function automatic logic [rgbv210_pkg::SAMPLE_W-1:0] chroma_avg(
			logic [rgbv210_pkg::SAMPLE_W-1:0] a, logic [rgbv210_pkg::SAMPLE_W-1:0] b);
		int s;
		s = (int'(a) + int'(b) + 1) >> 1;
		return s[rgbv210_pkg::SAMPLE_W-1:0];
	endfunction

	// Append one expected word
	task automatic expect_word(input v210_word_t w);
		pending_words.insert(pending_words.size(), w);
	endtask

	// Queue the four words of one six-pixel group
	task automatic queue_group(input logic [rgbv210_pkg::SAMPLE_W-1:0] y [6],
			input logic [rgbv210_pkg::SAMPLE_W-1:0] cb [6],
			input logic [rgbv210_pkg::SAMPLE_W-1:0] cr [6]);
		logic [rgbv210_pkg::SAMPLE_W-1:0] b0, b1, b2, r0, r1, r2;
		v210_word_t w;
		b0 = chroma_avg(cb[0], cb[1]);
		b1 = chroma_avg(cb[2], cb[3]);
		b2 = chroma_avg(cb[4], cb[5]);
		r0 = chroma_avg(cr[0], cr[1]);
		r1 = chroma_avg(cr[2], cr[3]);
		r2 = chroma_avg(cr[4], cr[5]);
		w.row_done = 1'b0;
		w.video_word = {r0, y[0], b0};
		expect_word(w);
		w.video_word = {y[2], b1, y[1]};
		expect_word(w);
		w.video_word = {b2, y[3], r1};
		expect_word(w);
		w.video_word = {y[5], r2, y[4]};
		expect_word(w);
		group_pos = group_pos + 3'd1;
	endtask

	// Advance the packer state by one accepted pixel
	task automatic pack_pixel(input pixel_t p);
		logic [rgbv210_pkg::SAMPLE_W-1:0] y [6];
		logic [rgbv210_pkg::SAMPLE_W-1:0] cb [6];
		logic [rgbv210_pkg::SAMPLE_W-1:0] cr [6];
		logic [rgbv210_pkg::SAMPLE_W-1:0] ys, bs, rs;
		int width, s;
		bit last;
		v210_word_t w;
		width = (cfg_width > rgbv210_pkg::MAX_ROW_WIDTH) ?
			int'(rgbv210_pkg::MAX_ROW_WIDTH) : int'(cfg_width);
		s = (slot_pos > 3'd5) ? 5 : int'(slot_pos);
		last = (int'(col_pos) + 1) >= width;
		if (cfg_key)
			rgb_to_ycc(scale_to_10(p.alpha), scale_to_10(p.alpha), scale_to_10(p.alpha),
				ys, bs, rs);
		else
			rgb_to_ycc(scale_to_10(p.red), scale_to_10(p.green), scale_to_10(p.blue),
				ys, bs, rs);
		if (s < 5 && !last) begin
			luma_hold[s] = ys;
			cb_hold[s]   = bs;
			cr_hold[s]   = rs;
			slot_pos = 3'(s + 1);
			col_pos  = col_pos + 1'b1;
			return;
		end
		for (int i = 0; i < 6; i++) begin
			if (i < s) begin
				y[i] = luma_hold[i]; cb[i] = cb_hold[i]; cr[i] = cr_hold[i];
			end else if (i == s) begin
				y[i] = ys; cb[i] = bs; cr[i] = rs;
			end else begin
				y[i] = rgbv210_pkg::BLACK_Y;
				cb[i] = rgbv210_pkg::BLACK_C;
				cr[i] = rgbv210_pkg::BLACK_C;
			end
		end
		queue_group(y, cb, cr);
		slot_pos = 3'd0;
		if (!last) begin
			col_pos = col_pos + 1'b1;
			return;
		end
		// Pad the row with black groups up to the 48-pixel block
		for (int i = 0; i < 6; i++) begin
			y[i] = rgbv210_pkg::BLACK_Y;
			cb[i] = rgbv210_pkg::BLACK_C;
			cr[i] = rgbv210_pkg::BLACK_C;
		end
		while (group_pos != 3'd0)
			queue_group(y, cb, cr);
		w = pending_words.pop_back();
		w.row_done = 1'b1;
		expect_word(w);
		col_pos = '0;
	endtask

	// Word checker
	always @(posedge clk) begin
		v210_word_t want;
		if (arst_n && word_bus.valid && word_bus.ready) begin
			words_checked++;
			if (word_bus.row_done) rows_seen++;
			if (pending_words.size() == 0) begin
				failures++;
				$display("%0t: unexpected word %h row_done %b", $time,
					word_bus.video_word, word_bus.row_done);
			end else begin
				want = pending_words.pop_front();
				if (word_bus.video_word !== want.video_word) begin
					failures++;
					$display("%0t: video_word expected %h actual %h", $time,
						want.video_word, word_bus.video_word);
				end
				if (word_bus.row_done !== want.row_done) begin
					failures++;
					$display("%0t: row_done expected %b actual %b", $time,
						want.row_done, word_bus.row_done);
				end
			end
		end
	end

	// Word receiver: random stalls, plus long hold-offs on request
	initial begin : receiver
		int hold_left;
		int seen;
		hold_left = 0;
		seen = 0;
		word_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != seen) begin
				seen = hold_request;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				word_bus.ready <= 1'b0;
			end else begin
				word_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Send one pixel, with random idle cycles ahead of it
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.red   <= p.red;
		pix_bus.green <= p.green;
		pix_bus.blue  <= p.blue;
		pix_bus.alpha <= p.alpha;
		@(posedge clk);
		while (!pix_bus.ready) @(posedge clk);
		pack_pixel(p);
		pixels_sent++;
	endtask

	// Stop sending, wait for every word, then let the pipeline settle
	task automatic drain();
		pix_bus.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rgbv210_pkg::CFG_INDEX_W-1:0] idx,
			input logic [rgbv210_pkg::CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		case (idx)
			rgbv210_pkg::REG_WIDE_GAMUT: cfg_bt2020 = data[0];
			rgbv210_pkg::REG_ALPHA_KEY:  cfg_key    = data[0];
			rgbv210_pkg::REG_ROW_WIDTH:  cfg_width  = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic pixel_t make_pixel(int r, int g, int b, int a);
		pixel_t p;
		p.red = r[7:0]; p.green = g[7:0]; p.blue = b[7:0]; p.alpha = a[7:0];
		return p;
	endfunction

	function automatic logic [rgbv210_pkg::CHAN_W-1:0] random_channel();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.red = random_channel(); p.green = random_channel();
		p.blue = random_channel(); p.alpha = random_channel();
		return p;
	endfunction

	// Flag value, sometimes with junk in the unused data bits
	function automatic logic [rgbv210_pkg::CFG_DATA_W-1:0] flag_data(bit b);
		logic [rgbv210_pkg::CFG_DATA_W-1:0] d;
		d = ($urandom_range(3) == 0) ? rgbv210_pkg::CFG_DATA_W'($urandom) : '0;
		d[0] = b;
		return d;
	endfunction

	// Reset defaults: BT.709, 1920 wide, so no row end here
	task automatic test_reset_defaults();
		send_pixel(make_pixel(0, 0, 0, 0));
		send_pixel(make_pixel(255, 255, 255, 255));
		send_pixel(make_pixel(255, 0, 0, 0));
		send_pixel(make_pixel(0, 255, 0, 0));
		send_pixel(make_pixel(0, 0, 255, 0));
		send_pixel(make_pixel(255, 255, 0, 128));
		send_pixel(make_pixel(0, 255, 255, 1));
		send_pixel(make_pixel(255, 0, 255, 254));
		drain();
	endtask

	// Shorter row: held pixels finish as a partial group with black fill
	task automatic test_partial_group();
		write_reg(rgbv210_pkg::REG_ROW_WIDTH, 13'd10);
		send_pixel(make_pixel(1, 2, 3, 4));
		send_pixel(make_pixel(254, 253, 252, 251));
		drain();
	endtask

	// BT.2020 with key mode, one full group ending the row
	task automatic test_bt2020_key();
		write_reg(rgbv210_pkg::REG_WIDE_GAMUT, 13'd1);
		write_reg(rgbv210_pkg::REG_ALPHA_KEY, 13'd1);
		write_reg(rgbv210_pkg::REG_ROW_WIDTH, 13'd6);
		write_reg(REG_SPARE, 13'h1FFF);
		send_pixel(make_pixel(255, 255, 255, 0));
		send_pixel(make_pixel(0, 0, 0, 255));
		send_pixel(make_pixel(17, 200, 90, 128));
		send_pixel(make_pixel(0, 0, 0, 1));
		send_pixel(make_pixel(255, 0, 0, 254));
		send_pixel(make_pixel(0, 255, 0, 77));
		drain();
	endtask

	// Width zero: every pixel ends a row; hold the receiver so the queue fills
	// and the input stalls while pixels keep coming
	task automatic test_width_zero();
		write_reg(rgbv210_pkg::REG_ALPHA_KEY, 13'd0);
		write_reg(rgbv210_pkg::REG_ROW_WIDTH, 13'd0);
		hold_request++;
		send_pixel(make_pixel(255, 255, 255, 0));
		send_pixel(make_pixel(0, 0, 0, 0));
		send_pixel(make_pixel(128, 64, 32, 0));
		send_pixel(make_pixel(0, 128, 255, 0));
		for (int i = 0; i < 6; i++)
			send_pixel(random_pixel());
		drain();
	endtask

	// Shrink the width mid-row, then single-pixel rows
	task automatic test_width_shrink();
		write_reg(rgbv210_pkg::REG_WIDE_GAMUT, 13'd0);
		write_reg(rgbv210_pkg::REG_ROW_WIDTH, rgbv210_pkg::MAX_ROW_WIDTH);
		send_pixel(make_pixel(10, 20, 30, 40));
		send_pixel(make_pixel(200, 100, 50, 25));
		send_pixel(make_pixel(255, 128, 0, 9));
		drain();
		write_reg(rgbv210_pkg::REG_ROW_WIDTH, 13'd2);
		send_pixel(make_pixel(90, 180, 45, 3));
		drain();
		write_reg(rgbv210_pkg::REG_ROW_WIDTH, 13'd1);
		send_pixel(make_pixel(255, 255, 255, 255));
		drain();
	endtask

	// Random rows with a fresh setting per segment
	task automatic test_random_rows(input int n_items);
		int sent, seg, pick;
		logic [rgbv210_pkg::CFG_DATA_W-1:0] width;
		sent = 0;
		while (sent < n_items) begin
			drain();
			pick = $urandom_range(15);
			if (pick < 12) width = rgbv210_pkg::CFG_DATA_W'($urandom_range(1, 48));
			else if (pick < 14) width = rgbv210_pkg::CFG_DATA_W'($urandom_range(49, 200));
			else width = rgbv210_pkg::CFG_DATA_W'($urandom);
			write_reg(rgbv210_pkg::REG_WIDE_GAMUT, flag_data(1'($urandom_range(1))));
			write_reg(rgbv210_pkg::REG_ALPHA_KEY, flag_data($urandom_range(3) == 0));
			write_reg(rgbv210_pkg::REG_ROW_WIDTH, width);
			seg = (width == 0) ? $urandom_range(1, 3) : $urandom_range(8, 30);
			for (int i = 0; i < seg; i++)
				send_pixel(random_pixel());
			sent += seg;
		end
		drain();
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= rgbv210_pkg::REG_WIDE_GAMUT;
		cfg_bus.data  <= '0;
		pix_bus.valid <= 1'b0;
		pix_bus.red   <= '0;
		pix_bus.green <= '0;
		pix_bus.blue  <= '0;
		pix_bus.alpha <= '0;
		cfg_bt2020 = 1'b0;
		cfg_key    = 1'b0;
		cfg_width  = rgbv210_pkg::ROW_WIDTH_RESET;
		col_pos    = '0;
		slot_pos   = '0;
		group_pos  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 69;
		test_reset_defaults();
		test_partial_group();
		test_bt2020_key();
		test_width_zero();
		test_width_shrink();

		test_random_rows(75);
		send_idle_pct = 69;
		recv_idle_pct = 14;
		test_random_rows(75);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_rows(75);

		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d pixels, %0d v210 words and %0d padded rows", pixels_sent,
			words_checked, rows_seen);
		$display("across BT.709/BT.2020, key mode and row widths 0 to 8191");
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
